@@ hw/rtl/rpc_pkg.sv @@
// Shared types, constants and rotate helpers for the Red Pike cipher unit.
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int unsigned NumRounds = 16;
  localparam logic [31:0] Delta = 32'h9E37_79B9;
  localparam logic [63:0] OffsetWide = 64'(Delta) * 64'(NumRounds + 1);
  localparam logic [31:0] KeyOffset = OffsetWide[31:0];
  localparam int unsigned Latency = NumRounds + 1;

  localparam int unsigned AddrWidth = 3;
  localparam logic RegKeyLow = 1'b0;
  localparam logic RegKeyHigh = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] word_a_in;
    logic [31:0] word_b_in;
  } rpc_in_t;

  typedef struct packed {
    logic [31:0] word_a_out;
    logic [31:0] word_b_out;
  } rpc_out_t;

  typedef struct packed {
    logic [31:0] key_low;
    logic [31:0] key_high;
  } rpc_key_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] k0;
    logic [31:0] k1;
  } rpc_stage_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} >> s;
    return t[31:0];
  endfunction

endpackage

@@ hw/rtl/red_pike_block_cipher_unit.sv @@
// Top level of the pipelined Red Pike 64-bit block cipher unit.
`timescale 1ns / 1ps

// Usage: a beat enters on start while busy is low; busy is always low, so a
// new block may enter in every cycle. The beat carries a mode bit (0 encrypt,
// 1 decrypt) and two 32-bit words.
// The result beat appears on out_o for exactly one cycle, marked by done,
// once the block has passed one input stage that derives the round
// keys, then one pipeline stage per round for the 16 rounds.
// Throughput is one block per cycle; the stages set the latency.
// The two key words are written through the APB port (key_low at byte
// address 0, key_high at byte address 4) and must only change while no
// block is in flight. Reset clears the keys and all stage valid bits, so
// no result beat follows reset. The receiver cannot stall; every result
// beat must be taken in the cycle it is shown.
module red_pike_block_cipher_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  rpc_pkg::rpc_in_t                 in_i,
  output logic                             done,
  output rpc_pkg::rpc_out_t                out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rpc_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  rpc_pkg::rpc_key_t   key;
  logic                accept;
  logic                valid_in_q;
  rpc_pkg::rpc_stage_t stage_in_q;
  logic                valid_q [rpc_pkg::NumRounds+1];
  rpc_pkg::rpc_stage_t stage_q [rpc_pkg::NumRounds+1];
  rpc_pkg::rpc_stage_t entry_d;

  rpc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    entry_d.a = in_i.word_a_in;
    entry_d.b = in_i.word_b_in;
    if (in_i.mode) begin
      entry_d.k0 = key.key_high - rpc_pkg::KeyOffset;
      entry_d.k1 = key.key_low + rpc_pkg::KeyOffset;
    end else begin
      entry_d.k0 = key.key_low;
      entry_d.k1 = key.key_high;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_in_q <= 1'b0;
    end else begin
      valid_in_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_in_q <= entry_d;
    end
  end

  assign valid_q[0] = valid_in_q;
  assign stage_q[0] = stage_in_q;

  for (genvar r = 0; r < rpc_pkg::NumRounds; r++) begin : g_round
    rpc_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_q[r]),
      .stage_i (stage_q[r]),
      .valid_o (valid_q[r+1]),
      .stage_o (stage_q[r+1])
    );
  end

  assign done             = valid_q[rpc_pkg::NumRounds];
  assign out_o.word_a_out = stage_q[rpc_pkg::NumRounds].b;
  assign out_o.word_b_out = stage_q[rpc_pkg::NumRounds].a;

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done == $past(accept && rst_ni, rpc_pkg::Latency))
    else $error("result beat does not follow its input beat at fixed latency");

  a_enc_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.mode) |=>
      (stage_q[0].k0 == key.key_low && stage_q[0].k1 == key.key_high))
    else $error("encrypt beat entered with wrong key words");

  a_dec_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.mode) |=>
      (stage_q[0].k0 + rpc_pkg::KeyOffset == key.key_high &&
       stage_q[0].k1 - rpc_pkg::KeyOffset == key.key_low))
    else $error("decrypt beat entered with wrong derived key words");

endmodule

@@ hw/rtl/rpc_cfg.sv @@
// APB register file holding the two cipher key words.
`timescale 1ns / 1ps

module rpc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rpc_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output rpc_pkg::rpc_key_t                key_o
);

  logic [31:0] key_low_q, key_low_d;
  logic [31:0] key_high_q, key_high_d;
  logic        wr_en;
  logic        sel;

  assign sel    = paddr[2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    key_low_d  = key_low_q;
    key_high_d = key_high_q;
    if (wr_en) begin
      unique case (sel)
        rpc_pkg::RegKeyLow:  key_low_d  = pwdata;
        rpc_pkg::RegKeyHigh: key_high_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else begin
      key_low_q  <= key_low_d;
      key_high_q <= key_high_d;
    end
  end

  always_comb begin
    unique case (sel)
      rpc_pkg::RegKeyLow:  prdata = key_low_q;
      rpc_pkg::RegKeyHigh: prdata = key_high_q;
      default:             prdata = '0;
    endcase
  end

  assign key_o.key_low  = key_low_q;
  assign key_o.key_high = key_high_q;

endmodule

@@ hw/rtl/rpc_round.sv @@
// One registered cipher round: key schedule step and data mixing.
`timescale 1ns / 1ps

module rpc_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rpc_pkg::rpc_stage_t stage_i,
  output logic                valid_o,
  output rpc_pkg::rpc_stage_t stage_o
);

  logic                valid_q;
  rpc_pkg::rpc_stage_t stage_q, stage_d;

  always_comb begin
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] wa;
    logic [31:0] wb;
    k0 = stage_i.k0 + rpc_pkg::Delta;
    k1 = stage_i.k1 - rpc_pkg::Delta;
    wa = (stage_i.a ^ k0) + stage_i.b;
    wa = rpc_pkg::rotl(wa, stage_i.b[4:0]);
    wb = rpc_pkg::rotr(stage_i.b, wa[4:0]);
    wb = (wb - wa) ^ k1;
    stage_d.a  = wa;
    stage_d.b  = wb;
    stage_d.k0 = k0;
    stage_d.k1 = k1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the pipelined Red Pike block cipher unit.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [31:0] GOLDEN = 32'h9E37_79B9;
  localparam int unsigned ROUNDS = 16;
  localparam logic [31:0] KEY_SHIFT = GOLDEN * 32'd17;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned BLOCKS_PER_KEY = 112;

  class cipher_predictor;
    logic [31:0]       key_lo;
    logic [31:0]       key_hi;
    rpc_pkg::rpc_out_t expected_blocks[$];
    int unsigned       n_errors;
    int unsigned       n_encrypt;
    int unsigned       n_decrypt;

    function new();
      key_lo = '0;
      key_hi = '0;
      n_errors = 0;
      n_encrypt = 0;
      n_decrypt = 0;
    endfunction

    function void set_key(logic idx, logic [31:0] value);
      if (idx == rpc_pkg::RegKeyHigh) begin
        key_hi = value;
      end else begin
        key_lo = value;
      end
    endfunction

    function void note_block(rpc_pkg::rpc_in_t blk);
      logic [31:0]       k0;
      logic [31:0]       k1;
      logic [31:0]       wa;
      logic [31:0]       wb;
      logic [4:0]        s;
      rpc_pkg::rpc_out_t res;
      // Decryption uses the swapped key words, offset by the constant sum.
      k0 = blk.mode ? key_hi - KEY_SHIFT : key_lo;
      k1 = blk.mode ? key_lo + KEY_SHIFT : key_hi;
      wa = blk.word_a_in;
      wb = blk.word_b_in;
      for (int r = 0; r < ROUNDS; r++) begin
        k0 = k0 + GOLDEN;
        k1 = k1 - GOLDEN;
        wa = wa ^ k0;
        wa = wa + wb;
        s = wb[4:0];
        if (s != 5'd0) wa = (wa << s) | (wa >> (6'd32 - s));
        s = wa[4:0];
        if (s != 5'd0) wb = (wb >> s) | (wb << (6'd32 - s));
        wb = wb - wa;
        wb = wb ^ k1;
      end
      res.word_a_out = wb;
      res.word_b_out = wa;
      expected_blocks.push_back(res);
      if (blk.mode) n_decrypt++;
      else n_encrypt++;
    endfunction

    function void check_block(rpc_pkg::rpc_out_t got);
      rpc_pkg::rpc_out_t want;
      if (expected_blocks.size() == 0) begin
        $error("result beat with no block pending: %h %h", got.word_a_out, got.word_b_out);
        n_errors++;
        return;
      end
      want = expected_blocks.pop_front();
      if (got.word_a_out !== want.word_a_out) begin
        $error("word_a_out: expected %h, actual %h", want.word_a_out, got.word_a_out);
        n_errors++;
      end
      if (got.word_b_out !== want.word_b_out) begin
        $error("word_b_out: expected %h, actual %h", want.word_b_out, got.word_b_out);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  rpc_pkg::rpc_in_t                  in_i = '0;
  logic                              done;
  rpc_pkg::rpc_out_t                 out_o;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [rpc_pkg::AddrWidth-1:0]     paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;

  cipher_predictor cipher_model = new();
  int unsigned     cycle_count = 0;
  int unsigned     key_settings = 0;

  red_pike_block_cipher_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done   (done),
    .out_o  (out_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d blocks pending.",
               cycle_count, cipher_model.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done) cipher_model.check_block(out_o);
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom & 32'hFFFF_FFE0;
      3: return 32'h0000_0001 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_key(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cipher_model.set_key(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_block(input rpc_pkg::rpc_in_t blk, input int unsigned gap);
    rpc_pkg::rpc_in_t noise;
    start <= 1'b1;
    in_i <= blk;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cipher_model.note_block(blk);
    if (gap > 0) begin
      noise.mode = 1'($urandom_range(0, 1));
      noise.word_a_in = $urandom;
      noise.word_b_in = $urandom;
      start <= 1'b0;
      in_i <= noise;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (cipher_model.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_key_phase(input logic [31:0] klo, input logic [31:0] khi);
    rpc_pkg::rpc_in_t blk;
    bit               burst;
    wait_idle();
    write_key(rpc_pkg::RegKeyLow, klo);
    write_key(rpc_pkg::RegKeyHigh, khi);
    key_settings++;
    burst = 1'b0;
    for (int i = 0; i < BLOCKS_PER_KEY; i++) begin
      if (i % 16 == 0) burst = ($urandom_range(0, 9) < 3);
      blk.mode = 1'($urandom_range(0, 1));
      blk.word_a_in = pick_word();
      blk.word_b_in = pick_word();
      send_block(blk, burst ? 0 : $urandom_range(0, 8));
    end
  endtask

  initial begin
    logic [31:0]      edge_a[8];
    logic [31:0]      edge_b[8];
    rpc_pkg::rpc_in_t blk;
    edge_a = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
               32'h1, 32'h8000_0000, 32'h1234_5678, 32'hDEAD_BEEF};
    edge_b = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
               32'h8000_0000, 32'h20, 32'hC0, 32'h1F};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset keys first: word_b values with zero low bits hit the identity rotate.
    key_settings++;
    for (int m = 0; m < 2; m++) begin
      for (int i = 0; i < 8; i++) begin
        blk.mode = m[0];
        blk.word_a_in = edge_a[i];
        blk.word_b_in = edge_b[i];
        send_block(blk, (i % 3 == 0) ? 0 : $urandom_range(0, 8));
      end
    end

    run_key_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_key_phase(32'h0000_0000, 32'hFFFF_FFFF);
    run_key_phase(32'hFFFF_FFFF, 32'h0000_0000);
    run_key_phase(32'h0000_0000, 32'h0000_0000);
    for (int p = 0; p < 6; p++) run_key_phase($urandom, $urandom);

    wait_idle();
    if (cipher_model.pending() != 0) begin
      $error("%0d expected blocks never arrived", cipher_model.pending());
      cipher_model.n_errors++;
    end
    $display("Run covered %0d encrypt and %0d decrypt blocks over %0d key settings,",
             cipher_model.n_encrypt, cipher_model.n_decrypt, key_settings);
    $display("with input gaps of 0 to 8 cycles and back-to-back bursts.");
    if (cipher_model.n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ red_pike_block_cipher_unit.f @@
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_cfg.sv
hw/rtl/rpc_round.sv
hw/rtl/red_pike_block_cipher_unit.sv
dv/tb_top.sv
